>>> sv/fpa_pkg.sv
// ============================================================================
// fpa_pkg
// Shared types, codes and field widths of the first-fit aligned pool allocator.
// ============================================================================
package fpa_pkg;

  localparam int CMD_W    = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 4;
  localparam int BYTES_W  = 21;
  localparam int COUNT_W  = 7;

  // Request codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REALLOC = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 4'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_ALIGN    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 4'd3;
  localparam logic [STATUS_W-1:0] ST_LARGE    = 4'd4;
  localparam logic [STATUS_W-1:0] ST_NODESC   = 4'd5;
  localparam logic [STATUS_W-1:0] ST_NOMEM    = 4'd6;
  localparam logic [STATUS_W-1:0] ST_NULL     = 4'd7;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 4'd8;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_INS_INIT,
    OP_MOVE_INS,
    OP_INS_WRITE,
    OP_DEL_INIT,
    OP_MOVE_DEL,
    OP_DEL_FINISH,
    OP_SHRINK,
    OP_PUBLISH
  } dp_op_t;

  typedef enum logic [1:0] {
    SCAN_FIT,
    SCAN_FIND,
    SCAN_GAP
  } scan_mode_t;

  typedef enum logic [1:0] {
    ADDR_NONE,
    ADDR_OLD,
    ADDR_PLACE
  } addr_sel_t;

  typedef enum logic [1:0] {
    JOB_ALLOC,
    JOB_FREE,
    JOB_REALLOC,
    JOB_RELEASE_OLD
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND_INIT,
    S_FIND,
    S_REALLOC_DECIDE,
    S_FIT_INIT,
    S_FIT,
    S_INS_INIT,
    S_INS_MOVE,
    S_INS_WRITE,
    S_DEL_INIT,
    S_DEL_MOVE,
    S_DEL_FINISH,
    S_GAP_INIT,
    S_GAP,
    S_RESULT
  } state_t;

  typedef struct packed {
    dp_op_t               op;
    scan_mode_t           mode;
    logic                 set_res;
    logic [STATUS_W-1:0]  res_status;
    addr_sel_t            addr_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic                 addr_zero;
    logic                 size_zero;
    logic                 align_ok;
    logic [STATUS_W-1:0]  alloc_code;
    logic                 scan_done;
    logic                 scan_hit;
    logic                 move_done;
    logic                 shrink_fits;
  } dp_stat_t;

endpackage

>>> sv/first_fit_aligned_pool_allocator_unit.sv
// ============================================================================
// first_fit_aligned_pool_allocator_unit
// First-fit allocator with alignment over a pool described by a descriptor
// table.
// ============================================================================
// Requests arrive on the in_ channel (valid/ready) as command, address, size
// and alignment; each request yields exactly one transaction on the out_
// channel with status, address, bytes in use, live block count and largest
// free gap. The pool base is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while the block is idle, which the block does not enforce.
// One request is processed at a time. The descriptor table lives in a memory
// with one read and one write port and is walked one row per cycle, so the
// cost grows with N, the number of live blocks.
// At reset the table is empty, bytes in use and the count are zero, the
// largest gap is the whole pool and the pool base is zero.
// A finished result sits in the output register; the block accepts the next
// request while that result waits, and only stalls on publishing a second
// result while the receiver still holds back out_ready.
// ============================================================================
module first_fit_aligned_pool_allocator_unit #(
  parameter int POOL_BYTES  = 1048576,
  parameter int DESCRIPTORS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [fpa_pkg::DATA_W-1:0]      cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fpa_pkg::CMD_W-1:0]       in_command,
  input  logic [fpa_pkg::DATA_W-1:0]      in_address,
  input  logic [fpa_pkg::DATA_W-1:0]      in_size,
  input  logic [fpa_pkg::DATA_W-1:0]      in_alignment,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fpa_pkg::STATUS_W-1:0]    out_status,
  output logic [fpa_pkg::DATA_W-1:0]      out_result_address,
  output logic [fpa_pkg::BYTES_W-1:0]     out_bytes_in_use,
  output logic [fpa_pkg::COUNT_W-1:0]     out_live_blocks,
  output logic [fpa_pkg::BYTES_W-1:0]     out_largest_gap
);

  // Commands flow from the sequencer to the datapath; status flows back.
  fpa_pkg::dp_cmd_t  dp_cmd;
  fpa_pkg::dp_stat_t dp_stat;

  fpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  fpa_datapath #(
    .POOL_BYTES  (POOL_BYTES),
    .DESCRIPTORS (DESCRIPTORS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_command         (in_command),
    .in_address         (in_address),
    .in_size            (in_size),
    .in_alignment       (in_alignment),
    .cmd                (dp_cmd),
    .stat               (dp_stat),
    .out_status         (out_status),
    .out_result_address (out_result_address),
    .out_bytes_in_use   (out_bytes_in_use),
    .out_live_blocks    (out_live_blocks),
    .out_largest_gap    (out_largest_gap)
  );

endmodule

>>> sv/fpa_datapath.sv
// ============================================================================
// fpa_datapath
// Descriptor memory, request registers, scan evaluator and result registers.
// ============================================================================
module fpa_datapath #(
  parameter int POOL_BYTES  = 1048576,
  parameter int DESCRIPTORS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [fpa_pkg::DATA_W-1:0]          cfg_wr_data,
  input  logic [fpa_pkg::CMD_W-1:0]           in_command,
  input  logic [fpa_pkg::DATA_W-1:0]          in_address,
  input  logic [fpa_pkg::DATA_W-1:0]          in_size,
  input  logic [fpa_pkg::DATA_W-1:0]          in_alignment,
  input  fpa_pkg::dp_cmd_t                    cmd,
  output fpa_pkg::dp_stat_t                   stat,
  output logic [fpa_pkg::STATUS_W-1:0]        out_status,
  output logic [fpa_pkg::DATA_W-1:0]          out_result_address,
  output logic [fpa_pkg::BYTES_W-1:0]         out_bytes_in_use,
  output logic [fpa_pkg::COUNT_W-1:0]         out_live_blocks,
  output logic [fpa_pkg::BYTES_W-1:0]         out_largest_gap
);

  localparam int OW  = $clog2(POOL_BYTES + 1);
  localparam int IW  = $clog2(DESCRIPTORS + 1);
  localparam int AIW = $clog2(DESCRIPTORS);
  localparam int XW  = 34;
  localparam int DW  = fpa_pkg::DATA_W;
  localparam logic [OW-1:0] POOL_SPAN = OW'(POOL_BYTES);
  localparam logic [IW-1:0] DESC_MAX  = IW'(DESCRIPTORS);

  typedef struct packed {
    logic [OW-1:0] off;
    logic [OW-1:0] req;
    logic [OW-1:0] rnd;
  } row_t;

  // Descriptor memory: one write and one registered read per cycle.
  row_t           mem_r [DESCRIPTORS];
  row_t           q_r;
  logic [AIW-1:0] rd_addr;
  logic [AIW-1:0] wr_addr;
  logic           wr_en;
  row_t           wr_row;

  logic [DW-1:0]                  pool_base_r;
  logic [fpa_pkg::CMD_W-1:0]      cmd_r;
  logic [DW-1:0]                  addr_r;
  logic [DW-1:0]                  size_r;
  logic                           pow2_r;
  logic                           ovf_r;
  logic                           large_r;
  logic [OW-1:0]                  amask_r;
  logic [OW-1:0]                  rnd_r;

  logic [IW-1:0]  count_r;
  logic [OW-1:0]  used_r;
  logic [OW-1:0]  largest_r;
  logic [IW-1:0]  idx_r;
  logic [IW-1:0]  ev_j_r;
  logic           ev_vld_r;
  logic [IW-1:0]  mv_left_r;
  logic [OW-1:0]  prev_end_r;
  logic [OW-1:0]  best_r;
  logic [IW-1:0]  hit_idx_r;
  logic [OW-1:0]  hit_off_r;
  logic [OW-1:0]  hit_req_r;
  logic [OW-1:0]  hit_rnd_r;
  logic [OW-1:0]  place_off_r;
  logic [DW-1:0]  place_addr_r;
  logic [fpa_pkg::STATUS_W-1:0] res_status_r;
  logic [DW-1:0]  res_addr_r;

  // Request decode.
  logic [DW-1:0]  al_n;
  logic [DW-1:0]  al_m1;
  logic [DW:0]    sum_w;
  logic [DW-1:0]  rounded_w;

  assign al_n      = (in_alignment == '0) ? DW'(1) : in_alignment;
  assign al_m1     = al_n - DW'(1);
  assign sum_w     = {1'b0, in_size} + {1'b0, al_m1};
  assign rounded_w = sum_w[DW-1:0] & ~al_m1;

  // Scan evaluation of one gap or one descriptor.
  logic           last;
  logic [OW-1:0]  e_rel;
  logic [OW-1:0]  gap;
  logic           gap_ok;
  logic [XW-1:0]  s_abs;
  logic [XW-1:0]  a_abs;
  logic [XW-1:0]  a_rel;
  logic           fits;
  logic           match;
  logic           hit;
  logic [OW-1:0]  best_gap;

  assign last   = (ev_j_r == count_r);
  assign e_rel  = last ? POOL_SPAN : q_r.off;
  assign gap    = e_rel - prev_end_r;
  assign gap_ok = e_rel > prev_end_r;
  assign s_abs  = XW'(pool_base_r) + XW'(prev_end_r);
  assign a_abs  = (s_abs + XW'(amask_r)) & ~XW'(amask_r);
  assign a_rel  = a_abs - XW'(pool_base_r);
  assign fits   = (e_rel >= prev_end_r) && ((a_rel + XW'(rnd_r)) <= XW'(e_rel));
  assign match  = !last && ((pool_base_r + DW'(q_r.off)) == addr_r);
  assign best_gap = (gap_ok && (gap > best_r)) ? gap : best_r;

  always_comb begin
    case (cmd.mode)
      fpa_pkg::SCAN_FIT:  hit = ev_vld_r && fits;
      fpa_pkg::SCAN_FIND: hit = ev_vld_r && match;
      default:            hit = 1'b0;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    stat.command     = cmd_r;
    stat.addr_zero   = (addr_r == '0);
    stat.size_zero   = (size_r == '0);
    stat.align_ok    = pow2_r;
    stat.scan_hit    = hit;
    stat.scan_done   = ev_vld_r && (hit || last);
    stat.move_done   = (mv_left_r == '0) && !ev_vld_r;
    stat.shrink_fits = size_r <= DW'(hit_req_r);
    if (size_r == '0) begin
      stat.alloc_code = fpa_pkg::ST_ZERO;
    end else if (!pow2_r) begin
      stat.alloc_code = fpa_pkg::ST_ALIGN;
    end else if (ovf_r) begin
      stat.alloc_code = fpa_pkg::ST_OVERFLOW;
    end else if (large_r) begin
      stat.alloc_code = fpa_pkg::ST_LARGE;
    end else if (count_r >= DESC_MAX) begin
      stat.alloc_code = fpa_pkg::ST_NODESC;
    end else begin
      stat.alloc_code = fpa_pkg::ST_OK;
    end
  end

  // Memory port steering.
  logic [IW-1:0] ins_idx;
  logic [IW-1:0] del_idx;

  assign ins_idx = ev_j_r + IW'(1);
  assign del_idx = ev_j_r - IW'(1);
  assign rd_addr = idx_r[AIW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hit_idx_r[AIW-1:0];
    wr_row  = q_r;
    case (cmd.op)
      fpa_pkg::OP_MOVE_INS: begin
        wr_en   = ev_vld_r;
        wr_addr = ins_idx[AIW-1:0];
      end
      fpa_pkg::OP_MOVE_DEL: begin
        wr_en   = ev_vld_r;
        wr_addr = del_idx[AIW-1:0];
      end
      fpa_pkg::OP_INS_WRITE: begin
        wr_en  = 1'b1;
        wr_row = '{off: place_off_r, req: size_r[OW-1:0], rnd: rnd_r};
      end
      fpa_pkg::OP_SHRINK: begin
        wr_en  = 1'b1;
        wr_row = '{off: hit_off_r, req: size_r[OW-1:0], rnd: hit_rnd_r};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_row;
    end
    q_r <= mem_r[rd_addr];
  end

  // Control state of the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= '0;
      count_r     <= '0;
      used_r      <= '0;
      largest_r   <= POOL_SPAN;
      ev_vld_r    <= 1'b0;
      mv_left_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        pool_base_r <= cfg_wr_data;
      end
      case (cmd.op)
        fpa_pkg::OP_SCAN_INIT: begin
          ev_vld_r <= 1'b0;
        end
        fpa_pkg::OP_SCAN: begin
          ev_vld_r <= (idx_r <= count_r);
          if (ev_vld_r && (cmd.mode == fpa_pkg::SCAN_GAP) && last) begin
            largest_r <= best_gap;
          end
        end
        fpa_pkg::OP_INS_INIT: begin
          ev_vld_r  <= 1'b0;
          mv_left_r <= count_r - hit_idx_r;
        end
        fpa_pkg::OP_DEL_INIT: begin
          ev_vld_r  <= 1'b0;
          mv_left_r <= count_r - IW'(1) - hit_idx_r;
        end
        fpa_pkg::OP_MOVE_INS, fpa_pkg::OP_MOVE_DEL: begin
          ev_vld_r <= (mv_left_r != '0);
          if (mv_left_r != '0) begin
            mv_left_r <= mv_left_r - IW'(1);
          end
        end
        fpa_pkg::OP_INS_WRITE: begin
          count_r <= count_r + IW'(1);
          used_r  <= used_r + rnd_r;
        end
        fpa_pkg::OP_DEL_FINISH: begin
          count_r <= count_r - IW'(1);
          used_r  <= used_r - hit_rnd_r;
        end
        default: begin
          ev_vld_r <= ev_vld_r;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      fpa_pkg::OP_LOAD: begin
        cmd_r   <= in_command;
        addr_r  <= in_address;
        size_r  <= in_size;
        pow2_r  <= (al_n & al_m1) == '0;
        ovf_r   <= sum_w[DW];
        large_r <= rounded_w > DW'(POOL_BYTES);
        amask_r <= al_m1[OW-1:0];
        rnd_r   <= rounded_w[OW-1:0];
      end
      fpa_pkg::OP_SCAN_INIT: begin
        idx_r      <= '0;
        prev_end_r <= '0;
        best_r     <= '0;
      end
      fpa_pkg::OP_SCAN: begin
        if (idx_r <= count_r) begin
          idx_r  <= idx_r + IW'(1);
          ev_j_r <= idx_r;
        end
        if (ev_vld_r) begin
          prev_end_r <= q_r.off + q_r.rnd;
          best_r     <= best_gap;
          if ((cmd.mode == fpa_pkg::SCAN_FIT) && fits) begin
            hit_idx_r    <= ev_j_r;
            place_off_r  <= a_rel[OW-1:0];
            place_addr_r <= a_abs[DW-1:0];
          end
          if ((cmd.mode == fpa_pkg::SCAN_FIND) && match) begin
            hit_idx_r <= ev_j_r;
            hit_off_r <= q_r.off;
            hit_req_r <= q_r.req;
            hit_rnd_r <= q_r.rnd;
          end
        end
      end
      fpa_pkg::OP_INS_INIT: begin
        idx_r <= count_r - IW'(1);
      end
      fpa_pkg::OP_DEL_INIT: begin
        idx_r <= hit_idx_r + IW'(1);
      end
      fpa_pkg::OP_MOVE_INS: begin
        if (mv_left_r != '0) begin
          ev_j_r <= idx_r;
          idx_r  <= idx_r - IW'(1);
        end
      end
      fpa_pkg::OP_MOVE_DEL: begin
        if (mv_left_r != '0) begin
          ev_j_r <= idx_r;
          idx_r  <= idx_r + IW'(1);
        end
      end
      fpa_pkg::OP_PUBLISH: begin
        out_status         <= res_status_r;
        out_result_address <= res_addr_r;
        out_bytes_in_use   <= fpa_pkg::BYTES_W'(used_r);
        out_live_blocks    <= fpa_pkg::COUNT_W'(count_r);
        out_largest_gap    <= fpa_pkg::BYTES_W'(largest_r);
      end
      default: begin
        idx_r <= idx_r;
      end
    endcase
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      case (cmd.addr_sel)
        fpa_pkg::ADDR_OLD:   res_addr_r <= addr_r;
        fpa_pkg::ADDR_PLACE: res_addr_r <= place_addr_r;
        default:             res_addr_r <= '0;
      endcase
    end
  end

endmodule

>>> sv/fpa_ctrl.sv
// ============================================================================
// fpa_ctrl
// Request sequencer: walks alloc, free and realloc through datapath steps.
// ============================================================================
module fpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  fpa_pkg::dp_stat_t  stat,
  output fpa_pkg::dp_cmd_t   cmd
);

  fpa_pkg::state_t state_r, state_nxt;
  fpa_pkg::job_t   job_r, job_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpa_pkg::S_IDLE;
      job_r       <= fpa_pkg::JOB_ALLOC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == fpa_pkg::S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    cmd.op         = fpa_pkg::OP_IDLE;
    cmd.mode       = fpa_pkg::SCAN_GAP;
    cmd.set_res    = 1'b0;
    cmd.res_status = fpa_pkg::ST_OK;
    cmd.addr_sel   = fpa_pkg::ADDR_NONE;
    unique case (state_r)
      fpa_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op    = fpa_pkg::OP_LOAD;
          state_nxt = fpa_pkg::S_DISPATCH;
        end
      end
      fpa_pkg::S_DISPATCH: begin
        unique case (stat.command)
          fpa_pkg::CMD_ALLOC: begin
            if (stat.alloc_code != fpa_pkg::ST_OK) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = stat.alloc_code;
              state_nxt      = fpa_pkg::S_RESULT;
            end else begin
              job_nxt   = fpa_pkg::JOB_ALLOC;
              state_nxt = fpa_pkg::S_FIT_INIT;
            end
          end
          fpa_pkg::CMD_FREE: begin
            if (stat.addr_zero) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = fpa_pkg::ST_NULL;
              state_nxt      = fpa_pkg::S_RESULT;
            end else begin
              job_nxt   = fpa_pkg::JOB_FREE;
              state_nxt = fpa_pkg::S_FIND_INIT;
            end
          end
          fpa_pkg::CMD_REALLOC: begin
            if (stat.addr_zero) begin
              if (stat.alloc_code != fpa_pkg::ST_OK) begin
                cmd.set_res    = 1'b1;
                cmd.res_status = stat.alloc_code;
                state_nxt      = fpa_pkg::S_RESULT;
              end else begin
                job_nxt   = fpa_pkg::JOB_ALLOC;
                state_nxt = fpa_pkg::S_FIT_INIT;
              end
            end else if (stat.size_zero) begin
              job_nxt   = fpa_pkg::JOB_FREE;
              state_nxt = fpa_pkg::S_FIND_INIT;
            end else if (!stat.align_ok) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = fpa_pkg::ST_ALIGN;
              state_nxt      = fpa_pkg::S_RESULT;
            end else begin
              job_nxt   = fpa_pkg::JOB_REALLOC;
              state_nxt = fpa_pkg::S_FIND_INIT;
            end
          end
          default: begin
            cmd.set_res = 1'b1;
            state_nxt   = fpa_pkg::S_RESULT;
          end
        endcase
      end
      fpa_pkg::S_FIND_INIT: begin
        cmd.op    = fpa_pkg::OP_SCAN_INIT;
        cmd.mode  = fpa_pkg::SCAN_FIND;
        state_nxt = fpa_pkg::S_FIND;
      end
      fpa_pkg::S_FIND: begin
        cmd.op   = fpa_pkg::OP_SCAN;
        cmd.mode = fpa_pkg::SCAN_FIND;
        if (stat.scan_done) begin
          if (!stat.scan_hit) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = fpa_pkg::ST_UNKNOWN;
            state_nxt      = fpa_pkg::S_RESULT;
          end else if (job_r == fpa_pkg::JOB_REALLOC) begin
            state_nxt = fpa_pkg::S_REALLOC_DECIDE;
          end else begin
            state_nxt = fpa_pkg::S_DEL_INIT;
          end
        end
      end
      fpa_pkg::S_REALLOC_DECIDE: begin
        if (stat.shrink_fits) begin
          cmd.op         = fpa_pkg::OP_SHRINK;
          cmd.set_res    = 1'b1;
          cmd.res_status = fpa_pkg::ST_OK;
          cmd.addr_sel   = fpa_pkg::ADDR_OLD;
          state_nxt      = fpa_pkg::S_RESULT;
        end else if (stat.alloc_code != fpa_pkg::ST_OK) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = stat.alloc_code;
          cmd.addr_sel   = fpa_pkg::ADDR_OLD;
          state_nxt      = fpa_pkg::S_RESULT;
        end else begin
          state_nxt = fpa_pkg::S_FIT_INIT;
        end
      end
      fpa_pkg::S_FIT_INIT: begin
        cmd.op    = fpa_pkg::OP_SCAN_INIT;
        cmd.mode  = fpa_pkg::SCAN_FIT;
        state_nxt = fpa_pkg::S_FIT;
      end
      fpa_pkg::S_FIT: begin
        cmd.op   = fpa_pkg::OP_SCAN;
        cmd.mode = fpa_pkg::SCAN_FIT;
        if (stat.scan_done) begin
          if (stat.scan_hit) begin
            state_nxt = fpa_pkg::S_INS_INIT;
          end else begin
            cmd.set_res    = 1'b1;
            cmd.res_status = fpa_pkg::ST_NOMEM;
            cmd.addr_sel   = (job_r == fpa_pkg::JOB_REALLOC) ?
                             fpa_pkg::ADDR_OLD : fpa_pkg::ADDR_NONE;
            state_nxt      = fpa_pkg::S_RESULT;
          end
        end
      end
      fpa_pkg::S_INS_INIT: begin
        cmd.op    = fpa_pkg::OP_INS_INIT;
        state_nxt = fpa_pkg::S_INS_MOVE;
      end
      fpa_pkg::S_INS_MOVE: begin
        cmd.op = fpa_pkg::OP_MOVE_INS;
        if (stat.move_done) begin
          state_nxt = fpa_pkg::S_INS_WRITE;
        end
      end
      fpa_pkg::S_INS_WRITE: begin
        cmd.op         = fpa_pkg::OP_INS_WRITE;
        cmd.set_res    = 1'b1;
        cmd.res_status = fpa_pkg::ST_OK;
        cmd.addr_sel   = fpa_pkg::ADDR_PLACE;
        if (job_r == fpa_pkg::JOB_REALLOC) begin
          job_nxt   = fpa_pkg::JOB_RELEASE_OLD;
          state_nxt = fpa_pkg::S_FIND_INIT;
        end else begin
          state_nxt = fpa_pkg::S_GAP_INIT;
        end
      end
      fpa_pkg::S_DEL_INIT: begin
        cmd.op    = fpa_pkg::OP_DEL_INIT;
        state_nxt = fpa_pkg::S_DEL_MOVE;
      end
      fpa_pkg::S_DEL_MOVE: begin
        cmd.op = fpa_pkg::OP_MOVE_DEL;
        if (stat.move_done) begin
          state_nxt = fpa_pkg::S_DEL_FINISH;
        end
      end
      fpa_pkg::S_DEL_FINISH: begin
        cmd.op = fpa_pkg::OP_DEL_FINISH;
        if (job_r != fpa_pkg::JOB_RELEASE_OLD) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = fpa_pkg::ST_OK;
        end
        state_nxt = fpa_pkg::S_GAP_INIT;
      end
      fpa_pkg::S_GAP_INIT: begin
        cmd.op    = fpa_pkg::OP_SCAN_INIT;
        state_nxt = fpa_pkg::S_GAP;
      end
      fpa_pkg::S_GAP: begin
        cmd.op = fpa_pkg::OP_SCAN;
        if (stat.scan_done) begin
          state_nxt = fpa_pkg::S_RESULT;
        end
      end
      fpa_pkg::S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op    = fpa_pkg::OP_PUBLISH;
          state_nxt = fpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fpa_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.op == fpa_pkg::OP_PUBLISH) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule
